FILE: rtl/core/npcq_pkg.sv
// shared types and constants of the nearest palette color quantizer
`default_nettype none

package npcq_pkg;

  localparam int unsigned CH_W      = 8;
  localparam int unsigned IDX_W     = 4;
  localparam int unsigned CNT_W     = 5;
  localparam int unsigned SQ_W      = 2 * CH_W;
  localparam int unsigned DIST_W    = SQ_W + 2;
  localparam int unsigned MAX_SLOTS = 16;

  localparam logic [CNT_W-1:0] COLORS_RESET = 5'd16;

  typedef enum logic [0:0] {
    CMD_LOAD  = 1'b0,
    CMD_PIXEL = 1'b1
  } cmd_e;

  typedef struct packed {
    logic [0:0]       cmd;
    logic [IDX_W-1:0] entry_index;
    logic [CH_W-1:0]  red;
    logic [CH_W-1:0]  green;
    logic [CH_W-1:0]  blue;
  } in_t;

  typedef struct packed {
    logic [CH_W-1:0]  red_out;
    logic [CH_W-1:0]  green_out;
    logic [CH_W-1:0]  blue_out;
    logic [IDX_W-1:0] palette_index;
  } out_t;

  typedef struct packed {
    logic              en;
    logic [DIST_W-1:0] sum_sq;
    logic [IDX_W-1:0]  idx;
    logic [CH_W-1:0]   red;
    logic [CH_W-1:0]   green;
    logic [CH_W-1:0]   blue;
  } node_t;

endpackage

`default_nettype wire

FILE: rtl/core/npcq_dist.sv
// one palette lane: squared channel differences, then their sum, two register stages
`default_nettype none

module npcq_dist #(
  parameter int unsigned LANE = 0
) (
  input  wire                            clk_i,
  input  wire                            rst_ni,
  input  wire                            adv_i,
  input  wire                            en_i,
  input  wire  [npcq_pkg::CH_W-1:0]      px_red_i,
  input  wire  [npcq_pkg::CH_W-1:0]      px_green_i,
  input  wire  [npcq_pkg::CH_W-1:0]      px_blue_i,
  input  wire  [3*npcq_pkg::CH_W-1:0]    entry_i,
  output npcq_pkg::node_t                node_o
);
  import npcq_pkg::*;

  logic [CH_W-1:0] e_red, e_green, e_blue;
  logic [CH_W-1:0] dr, dg, db;
  logic [SQ_W-1:0] sqr_d, sqg_d, sqb_d;
  logic [SQ_W-1:0] sqr_q, sqg_q, sqb_q;
  logic [CH_W-1:0] er_q, eg_q, eb_q;
  logic            en_q;
  node_t           node_d, node_q;

  assign e_red   = entry_i[3*CH_W-1:2*CH_W];
  assign e_green = entry_i[2*CH_W-1:CH_W];
  assign e_blue  = entry_i[CH_W-1:0];

  always_comb begin
    dr    = (px_red_i > e_red) ? (px_red_i - e_red) : (e_red - px_red_i);
    dg    = (px_green_i > e_green) ? (px_green_i - e_green) : (e_green - px_green_i);
    db    = (px_blue_i > e_blue) ? (px_blue_i - e_blue) : (e_blue - px_blue_i);
    sqr_d = SQ_W'(dr) * SQ_W'(dr);
    sqg_d = SQ_W'(dg) * SQ_W'(dg);
    sqb_d = SQ_W'(db) * SQ_W'(db);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      en_q <= 1'b0;
    end else if (adv_i) begin
      en_q <= en_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv_i) begin
      sqr_q <= sqr_d;
      sqg_q <= sqg_d;
      sqb_q <= sqb_d;
      er_q  <= e_red;
      eg_q  <= e_green;
      eb_q  <= e_blue;
    end
  end

  always_comb begin
    node_d.en     = en_q;
    node_d.sum_sq = DIST_W'(sqr_q) + DIST_W'(sqg_q) + DIST_W'(sqb_q);
    node_d.idx    = IDX_W'(LANE);
    node_d.red    = er_q;
    node_d.green  = eg_q;
    node_d.blue   = eb_q;
  end

  always_ff @(posedge clk_i) begin
    if (adv_i) begin
      node_q <= node_d;
    end
  end

  assign node_o = node_q;

endmodule

`default_nettype wire

FILE: rtl/core/nearest_palette_color_quantizer_core.sv
// nearest palette color quantizer: palette store, distance lanes, registered min tree
//
// channel  dir  handshake                 payload
// in       in   in_valid_i / in_stall_o   in_word_i  (npcq_pkg::in_t)
// out      out  out_valid_o / out_stall_i out_word_o (npcq_pkg::out_t)
// cfg      in   cfg_valid_i / cfg_ready_o cfg_data_i (colors_in_use)
//
// one word accepted per cycle unless a stalled output holds the pipeline; a pixel
// result passes the input register (loaded at its accepting edge), the square and
// sum stages of each lane and one register per level of the compare tree
// load words write the palette at acceptance and give no result
// reset clears valid bits and sets colors_in_use to 16; palette is unknown until loaded
// a stalled output holds the whole pipeline and raises in_stall_o in the same cycle
`default_nettype none

module nearest_palette_color_quantizer_core #(
  parameter int unsigned PALETTE_SIZE = 16
) (
  input  wire                          clk_i,
  input  wire                          rst_ni,
  input  wire                          in_valid_i,
  output logic                         in_stall_o,
  input  npcq_pkg::in_t                in_word_i,
  output logic                         out_valid_o,
  input  wire                          out_stall_i,
  output npcq_pkg::out_t               out_word_o,
  input  wire                          cfg_valid_i,
  output logic                         cfg_ready_o,
  input  wire  [npcq_pkg::CNT_W-1:0]   cfg_data_i
);
  import npcq_pkg::*;

  localparam int unsigned NE  = (PALETTE_SIZE < MAX_SLOTS) ? PALETTE_SIZE : MAX_SLOTS;
  localparam int unsigned LVL = $clog2(NE);
  localparam int unsigned NP  = 1 << LVL;

  function automatic node_t pick(input node_t a, input node_t b);
    return (b.en && (!a.en || (b.sum_sq < a.sum_sq))) ? b : a;
  endfunction

  logic               adv;
  logic               in_acc;
  logic [CNT_W-1:0]   colors_q;
  logic [3*CH_W-1:0]  pal_q [NE];
  logic               v1_q, vsq_q, vsum_q;
  logic [CH_W-1:0]    pr_q, pg_q, pb_q;
  logic [NE-1:0]      lane_en;
  logic [LVL-1:0]     tv_q;
  node_t              all_n [2*NP-1];
  node_t              node_q [NP-1];

  assign adv         = !tv_q[0] || !out_stall_i;
  assign in_stall_o  = !adv;
  assign in_acc      = in_valid_i && adv;
  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      colors_q <= COLORS_RESET;
    end else if (cfg_valid_i) begin
      colors_q <= cfg_data_i;
    end
  end

  // palette slots
  for (genvar k = 0; k < NE; k++) begin : g_pal
    always_ff @(posedge clk_i) begin
      if (in_acc && (in_word_i.cmd == CMD_LOAD) &&
          (in_word_i.entry_index == IDX_W'(k))) begin
        pal_q[k] <= {in_word_i.red, in_word_i.green, in_word_i.blue};
      end
    end
  end

  // pixel input stage
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q   <= 1'b0;
      vsq_q  <= 1'b0;
      vsum_q <= 1'b0;
    end else if (adv) begin
      v1_q   <= in_valid_i && (in_word_i.cmd == CMD_PIXEL);
      vsq_q  <= v1_q;
      vsum_q <= vsq_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      pr_q <= in_word_i.red;
      pg_q <= in_word_i.green;
      pb_q <= in_word_i.blue;
    end
  end

  // distance lanes feed the tree leaves
  for (genvar k = 0; k < NP; k++) begin : g_lane
    if (k < NE) begin : g_used
      assign lane_en[k] = (k == 0) || (CNT_W'(k) < colors_q);
      npcq_dist #(
        .LANE (k)
      ) u_dist (
        .clk_i      (clk_i),
        .rst_ni     (rst_ni),
        .adv_i      (adv),
        .en_i       (lane_en[k]),
        .px_red_i   (pr_q),
        .px_green_i (pg_q),
        .px_blue_i  (pb_q),
        .entry_i    (pal_q[k]),
        .node_o     (all_n[NP-1+k])
      );
    end else begin : g_pad
      assign all_n[NP-1+k] = '0;
    end
  end

  // compare tree, one register per level, lower index kept on ties
  for (genvar n = 0; n < NP - 1; n++) begin : g_node
    always_ff @(posedge clk_i) begin
      if (adv) begin
        node_q[n] <= pick(all_n[2*n+1], all_n[2*n+2]);
      end
    end
    assign all_n[n] = node_q[n];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tv_q <= '0;
    end else if (adv) begin
      tv_q[LVL-1] <= vsum_q;
      for (int d = 0; d < LVL - 1; d++) begin
        tv_q[d] <= tv_q[d+1];
      end
    end
  end

  assign out_valid_o              = tv_q[0];
  assign out_word_o.red_out       = node_q[0].red;
  assign out_word_o.green_out     = node_q[0].green;
  assign out_word_o.blue_out      = node_q[0].blue;
  assign out_word_o.palette_index = node_q[0].idx;

  a_root_en : assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> node_q[0].en)
    else $error("result without a compared entry");

  a_load_silent : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && !in_stall_o && (in_word_i.cmd == CMD_LOAD)) |=> !v1_q)
    else $error("load word entered the pixel pipeline");

  a_stall_back : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && out_stall_i) |-> in_stall_o)
    else $error("input taken while output is stalled");

  a_index_range : assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> ((CNT_W'(out_word_o.palette_index) < CNT_W'(NE))))
    else $error("palette index beyond stored entries");

endmodule

`default_nettype wire
